// ===== rtl/thi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thi_pkg
// Shared types and constants for the terrain height interpolation block.
// ----------------------------------------------------------------------------
package thi_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int FRAC_BITS = 8;

    localparam int ONE      = 1 << FRAC_BITS;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int COLS_W   = $clog2(MAX_DIM + 1);
    localparam int FRAC_W   = FRAC_BITS + 1;

    // fixed field widths
    localparam int HEIGHT_W = 16;
    localparam int COORD_W  = 24;
    localparam int INDEX_W  = 16;
    localparam int CFG_W    = 9;
    localparam int SHIFT_W  = 3;
    localparam int CFG_IDX_W = 2;

    // grid-relative position: coordinate plus half the grid extent
    localparam int OFS_W = $clog2(MAX_DIM) + (1 << SHIFT_W) - 1 + FRAC_BITS;
    localparam int POS_W = ((COORD_W > OFS_W) ? COORD_W : OFS_W) + 2;

    // interpolation arithmetic
    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int NUM_W  = PROD_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS  = 2'd0,
        CFG_GRID_ROWS  = 2'd1,
        CFG_CELL_SHIFT = 2'd2
    } cfg_idx_t;

    // one classified word handed from the front to the back
    typedef struct packed {
        op_t                        op;
        logic [INDEX_W-1:0]         load_index;
        logic signed [HEIGHT_W-1:0] load_height;
        logic [COL_W-1:0]           col;
        logic [ROW_W-1:0]           row;
        logic [FRAC_W-1:0]          dx;
        logic [FRAC_W-1:0]          dz;
        logic                       clamped;
        logic [COLS_W-1:0]          cols;
    } desc_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_RA,
        S_RB,
        S_RC,
        S_RD,
        S_CD,
        S_MUL,
        S_SUM,
        S_OUT
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/thi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thi_front
// Holds the grid registers, takes input words and maps query positions to a
// cell index and fractions before handing them to the queue.
// ----------------------------------------------------------------------------
module thi_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [thi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [thi_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [thi_pkg::INDEX_W-1:0]       s_load_index,
    input  wire logic signed [thi_pkg::HEIGHT_W-1:0] s_load_height,
    input  wire logic signed [thi_pkg::COORD_W-1:0]  s_coord_x,
    input  wire logic signed [thi_pkg::COORD_W-1:0]  s_coord_z,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output thi_pkg::desc_t                         push_data
);
    import thi_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
        logic              outside;
    } loc_t;

    logic [CFG_W-1:0]   grid_cols_reg;
    logic [CFG_W-1:0]   grid_rows_reg;
    logic [SHIFT_W-1:0] cell_shift_reg;

    logic                       hold_valid_reg, hold_valid_next;
    op_t                        op_reg;
    logic [INDEX_W-1:0]         index_reg;
    logic signed [HEIGHT_W-1:0] lheight_reg;
    logic signed [COORD_W-1:0]  x_reg;
    logic signed [COORD_W-1:0]  z_reg;

    logic [COLS_W-1:0]       cols_sat, rows_sat, cc, cr;
    logic [POS_W-1:0]        ofs_x, ofs_z;
    logic signed [POS_W-1:0] px, pz;
    loc_t                    loc_x, loc_z;
    logic                    in_accept;

    // cell index and fraction along one axis, saturating outside the grid
    function automatic loc_t locate(input logic signed [POS_W-1:0] p,
                                    input logic [SHIFT_W-1:0] sh,
                                    input logic [COLS_W-1:0] cells);
        logic signed [POS_W-1:0] q;
        logic [POS_W-1:0]        mask;
        logic [POS_W-1:0]        ps;
        logic [COLS_W-1:0]       last;
        loc_t                    res;
        q    = p >>> (sh + FRAC_BITS);
        mask = ~({POS_W{1'b1}} << (sh + FRAC_BITS));
        ps   = $unsigned(p) >> sh;
        last = cells - COLS_W'(1);
        if (p < 0) begin
            res.idx     = '0;
            res.frac    = '0;
            res.outside = 1'b1;
        end else if ($unsigned(q) >= POS_W'(cells)) begin
            res.idx     = IDX_W'(last);
            res.frac    = FRAC_W'(ONE);
            // exactly on the far edge is still inside
            res.outside = !(($unsigned(q) == POS_W'(cells)) &&
                            (($unsigned(p) & mask) == '0));
        end else begin
            res.idx     = IDX_W'($unsigned(q));
            res.frac    = {1'b0, ps[FRAC_BITS-1:0]};
            res.outside = 1'b0;
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg  <= CFG_W'(256);
            grid_rows_reg  <= CFG_W'(256);
            cell_shift_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_COLS:  grid_cols_reg  <= cfg_data;
                CFG_GRID_ROWS:  grid_rows_reg  <= cfg_data;
                CFG_CELL_SHIFT: cell_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready   = !hold_valid_reg || push_ready;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (in_accept) begin
            hold_valid_next = 1'b1;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg      <= op_t'(s_op);
            index_reg   <= s_load_index;
            lheight_reg <= s_load_height;
            x_reg       <= s_coord_x;
            z_reg       <= s_coord_z;
        end
    end

    always_comb begin
        if (grid_cols_reg < CFG_W'(3)) begin
            cols_sat = COLS_W'(3);
        end else if (32'(grid_cols_reg) > MAX_COLS) begin
            cols_sat = COLS_W'(MAX_COLS);
        end else begin
            cols_sat = COLS_W'(grid_cols_reg);
        end
        if (grid_rows_reg < CFG_W'(3)) begin
            rows_sat = COLS_W'(3);
        end else if (32'(grid_rows_reg) > MAX_ROWS) begin
            rows_sat = COLS_W'(MAX_ROWS);
        end else begin
            rows_sat = COLS_W'(grid_rows_reg);
        end
        cc = cols_sat - COLS_W'(1);
        cr = rows_sat - COLS_W'(1);
        // half the grid extent, cells times half a cell
        ofs_x = POS_W'(cc) << (cell_shift_reg + FRAC_BITS - 1);
        ofs_z = POS_W'(cr) << (cell_shift_reg + FRAC_BITS - 1);
        px    = POS_W'(x_reg) + $signed(ofs_x);
        pz    = $signed(ofs_z) - POS_W'(z_reg);
        loc_x = locate(px, cell_shift_reg, cc);
        loc_z = locate(pz, cell_shift_reg, cr);
    end

    assign push_valid             = hold_valid_reg;
    assign push_data.op           = op_reg;
    assign push_data.load_index   = index_reg;
    assign push_data.load_height  = lheight_reg;
    assign push_data.col          = COL_W'(loc_x.idx);
    assign push_data.row          = ROW_W'(loc_z.idx);
    assign push_data.dx           = loc_x.frac;
    assign push_data.dz           = loc_z.frac;
    assign push_data.clamped      = loc_x.outside || loc_z.outside;
    assign push_data.cols         = cols_sat;

endmodule
`default_nettype wire

// ===== rtl/thi_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thi_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module thi_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire thi_pkg::desc_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output thi_pkg::desc_t      pop_data
);
    import thi_pkg::*;

    desc_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count did not grow on push");

endmodule
`default_nettype wire

// ===== rtl/thi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thi_back
// Height store and interpolation sequencer: reads the four cell corners over
// the single read port, blends them over the chosen triangle and drives the
// output register.
// ----------------------------------------------------------------------------
module thi_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                pop_valid,
    output logic                                     pop_ready,
    input  wire thi_pkg::desc_t                      pop_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [thi_pkg::HEIGHT_W-1:0]      m_height,
    output logic                                     m_upper_triangle,
    output logic                                     m_clamped
);
    import thi_pkg::*;

    logic [HEIGHT_W-1:0] mem [DEPTH];

    back_state_t st_reg, st_next;
    desc_t       cur_reg;

    logic [ADDR_W-1:0]          base_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [HEIGHT_W-1:0]        rdata_reg;
    logic signed [HEIGHT_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [HEIGHT_W-1:0] h0_reg;
    logic signed [PROD_W-1:0]   p1_reg, p2_reg;
    logic                       upper_reg;

    logic signed [HEIGHT_W-1:0] res_height_reg;
    logic                       res_upper_reg;
    logic                       res_clamped_reg;

    logic                       m_valid_reg, m_valid_next;
    logic signed [HEIGHT_W-1:0] m_height_reg;
    logic                       m_upper_reg;
    logic                       m_clamped_reg;

    logic                    take, mem_we, out_free, out_load;
    logic [ROW_W+COLS_W:0]   base_sum;
    logic [FRAC_W:0]         frac_sum;
    logic                    upper_c;
    logic signed [DIFF_W-1:0] e1, e2;
    logic [FRAC_W-1:0]       w1, w2;
    logic signed [NUM_W-1:0] num, rnd;

    assign take     = pop_valid && pop_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    st_next = (pop_data.op == OP_LOAD) ? S_OUT : S_ADDR;
                end
            end
            S_ADDR: st_next = S_RA;
            S_RA:   st_next = S_RB;
            S_RB:   st_next = S_RC;
            S_RC:   st_next = S_RD;
            S_RD:   st_next = S_CD;
            S_CD:   st_next = S_MUL;
            S_MUL:  st_next = S_SUM;
            S_SUM:  st_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop_ready = 1'b0;
        out_load  = 1'b0;
        rd_addr   = base_reg;
        unique case (st_reg)
            S_IDLE: pop_ready = 1'b1;
            S_RB:   rd_addr   = base_reg + ADDR_W'(1);
            S_RC:   rd_addr   = base_reg + ADDR_W'(cur_reg.cols);
            S_RD:   rd_addr   = base_reg + ADDR_W'(cur_reg.cols) + ADDR_W'(1);
            S_OUT:  out_load  = out_free;
            default: ;
        endcase
    end

    assign mem_we = take && (pop_data.op == OP_LOAD) && (32'(pop_data.load_index) < DEPTH);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ADDR_W'(pop_data.load_index)] <= pop_data.load_height;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // blend setup: the lower-right triangle works from corner d
    always_comb begin
        base_sum = (ROW_W + COLS_W + 1)'(cur_reg.row * cur_reg.cols) +
                   (ROW_W + COLS_W + 1)'(cur_reg.col);
        frac_sum = {1'b0, cur_reg.dx} + {1'b0, cur_reg.dz};
        upper_c  = frac_sum < (FRAC_W + 1)'(ONE);
        if (upper_c) begin
            e1 = DIFF_W'(b_reg) - DIFF_W'(a_reg);
            e2 = DIFF_W'(c_reg) - DIFF_W'(a_reg);
            w1 = cur_reg.dx;
            w2 = cur_reg.dz;
        end else begin
            e1 = DIFF_W'(c_reg) - DIFF_W'(d_reg);
            e2 = DIFF_W'(b_reg) - DIFF_W'(d_reg);
            w1 = FRAC_W'(ONE) - cur_reg.dx;
            w2 = FRAC_W'(ONE) - cur_reg.dz;
        end
        num = (NUM_W'(h0_reg) <<< FRAC_BITS) + NUM_W'(p1_reg) + NUM_W'(p2_reg);
        rnd = (num + NUM_W'(ONE / 2)) >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cur_reg         <= pop_data;
            res_height_reg  <= pop_data.load_height;
            res_upper_reg   <= 1'b0;
            res_clamped_reg <= 1'b0;
        end
        if (st_reg == S_ADDR) begin
            base_reg <= ADDR_W'(base_sum);
        end
        if (st_reg == S_RB) a_reg <= $signed(rdata_reg);
        if (st_reg == S_RC) b_reg <= $signed(rdata_reg);
        if (st_reg == S_RD) c_reg <= $signed(rdata_reg);
        if (st_reg == S_CD) d_reg <= $signed(rdata_reg);
        if (st_reg == S_MUL) begin
            upper_reg <= upper_c;
            h0_reg    <= upper_c ? a_reg : d_reg;
            p1_reg    <= e1 * $signed({1'b0, w1});
            p2_reg    <= e2 * $signed({1'b0, w2});
        end
        if (st_reg == S_SUM) begin
            if (rnd > NUM_W'((1 << (HEIGHT_W - 1)) - 1)) begin
                res_height_reg <= HEIGHT_W'((1 << (HEIGHT_W - 1)) - 1);
            end else if (rnd < -NUM_W'(1 << (HEIGHT_W - 1))) begin
                res_height_reg <= HEIGHT_W'(1 << (HEIGHT_W - 1));
            end else begin
                res_height_reg <= HEIGHT_W'(rnd);
            end
            res_upper_reg   <= upper_reg;
            res_clamped_reg <= cur_reg.clamped;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_height_reg  <= res_height_reg;
            m_upper_reg   <= res_upper_reg;
            m_clamped_reg <= res_clamped_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_height         = m_height_reg;
    assign m_upper_triangle = m_upper_reg;
    assign m_clamped        = m_clamped_reg;

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && pop_data.op == OP_QUERY) |=> (st_reg == S_ADDR))
        else $error("query did not enter address step");

    a_sum_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_SUM) |=> (st_reg == S_OUT))
        else $error("sum step not followed by output step");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_reg == S_OUT))
        else $error("result word raised outside output step");

endmodule
`default_nettype wire

// ===== rtl/terrain_height_interpolation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// terrain_height_interpolation
// Heightmap store with triangle interpolation of height at a world position.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per load (s_op = 0, writes s_load_height at
//   s_load_index) or query (s_op = 1, position s_coord_x / s_coord_z).
//   m_ channel: one word per input word; loads echo the written height,
//   queries return the interpolated height, triangle and clamp flags.
//   cfg_ channel: grid columns (0), grid rows (1), cell shift (2); write
//   only while no word is in flight. Always ready.
//   The back end sequencer takes one word at a time: a query steps through
//   four corner reads on the single store read port, the registered read,
//   and multiply and sum steps; a load goes straight to the output step.
//   The front and a two-word queue keep taking input while the back works;
//   a stalled m_ready holds the output word and fills the queue and the
//   front holding register, after which s_ready drops.
//   Reset clears the control state and sets the grid to 256 x 256 with
//   unit cells; the height store is not cleared and must be loaded before
//   it is queried.
// ----------------------------------------------------------------------------
module terrain_height_interpolation (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [thi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [thi_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_op,
    input  wire logic [thi_pkg::INDEX_W-1:0]         s_load_index,
    input  wire logic signed [thi_pkg::HEIGHT_W-1:0] s_load_height,
    input  wire logic signed [thi_pkg::COORD_W-1:0]  s_coord_x,
    input  wire logic signed [thi_pkg::COORD_W-1:0]  s_coord_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [thi_pkg::HEIGHT_W-1:0]      m_height,
    output logic                                     m_upper_triangle,
    output logic                                     m_clamped
);
    import thi_pkg::*;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    desc_t push_data, pop_data;

    thi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_load_index  (s_load_index),
        .s_load_height (s_load_height),
        .s_coord_x     (s_coord_x),
        .s_coord_z     (s_coord_z),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    thi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    thi_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_data         (pop_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_height         (m_height),
        .m_upper_triangle (m_upper_triangle),
        .m_clamped        (m_clamped)
    );

endmodule
`default_nettype wire
